// ===== hw/rtl/bda_pkg.sv =====
`timescale 1ns / 1ps
// bda_pkg: shared constants, register indexes, state and status types of the
// box downsample averager. No dependencies.
package bda_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_FACTOR_DEF = 8;
    localparam int HEIGHT_CAP     = 4096;
    localparam int NUM_CH         = 3;
    localparam int CH_W           = 8;
    localparam int COORD_W        = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SCALE_W    = 4;
    localparam int DIM_W      = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET  = 4'd2;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd1024;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DIV
    } bda_state_t;

    // divider status toward the control logic
    typedef struct packed {
        logic                         done;
        logic [NUM_CH-1:0][CH_W-1:0]  quot;
    } div_stat_t;

endpackage

// ===== hw/rtl/bda_line_store.sv =====
`timescale 1ns / 1ps
// bda_line_store: single-port-write, single-port-read line memory holding the
// partial block column sums. Uses no package items.
module bda_line_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 42
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bda_divider.sv =====
`timescale 1ns / 1ps
// bda_divider: restoring divider, one quotient bit per cycle, three channels
// sharing one divisor. Depends on bda_pkg.
module bda_divider #(
    parameter int SUMW = 14,
    parameter int CNTW = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic                                   take,
    input  logic [bda_pkg::NUM_CH-1:0][SUMW-1:0]   dividend,
    input  logic [CNTW-1:0]                        divisor,
    output bda_pkg::div_stat_t                     stat
);
    import bda_pkg::*;

    localparam int SCW = $clog2(SUMW + 1);

    logic [NUM_CH-1:0][SUMW-1:0] quo_reg, quo_next;
    logic [NUM_CH-1:0][CNTW-1:0] rem_reg, rem_next;
    logic [CNTW-1:0]             dvs_reg, dvs_next;
    logic [SCW-1:0]              cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [NUM_CH-1:0][CNTW:0]   trial;
    logic [NUM_CH-1:0]           ge;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            trial[c] = {rem_reg[c], quo_reg[c][SUMW-1]};
            ge[c]    = trial[c] >= {1'b0, dvs_reg};
        end
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = SCW'(SUMW);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                quo_next[c] = {quo_reg[c][SUMW-2:0], ge[c]};
                rem_next[c] = ge[c] ? CNTW'(trial[c] - {1'b0, dvs_reg})
                                    : CNTW'(trial[c]);
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SCW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (take) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        stat.done = done_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            stat.quot[c] = quo_reg[c][CH_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/box_downsample_averager.sv =====
`timescale 1ns / 1ps
// box_downsample_averager: a pixel that does not end a block column is taken without leaving
// ST_IDLE; one that ends a block column goes on to ST_MERGE (line store read at accept, then
// merge and write back); one that ends a block passes ST_MERGE, then waits in ST_DIV for the
// bit-serial divider, longer while the output register still holds an unaccepted item.
// aresetn (synchronous) restores register defaults and frame position 0; the line store
// is not cleared. Depends on bda_pkg, bda_line_store, bda_divider.
module box_downsample_averager #(
    parameter int MAX_WIDTH  = bda_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bda_pkg::MAX_FACTOR_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [bda_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16],
    // out_column [35:24], out_row [47:36]
    output logic [bda_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [bda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bda_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = CW + 1;
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int CNTW = 2 * FW;
    localparam int RSW  = $clog2(255 * MAX_FACTOR + 1);
    localparam int SUMW = $clog2(255 * MAX_FACTOR * MAX_FACTOR + 1);
    localparam int RW   = COORD_W;

    // configuration
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               restart;

    logic [FW-1:0]      f_eff;
    logic [CMPW-1:0]    w_eff;
    logic [DIM_W-1:0]   h_eff;

    // frame position and running row sum
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [FW-1:0]      cib_reg, cib_next;
    logic [FW-1:0]      rib_reg, rib_next;
    logic [CW-1:0]      bcol_reg, bcol_next;
    logic [RW-1:0]      brow_reg, brow_next;
    logic [NUM_CH-1:0][RSW-1:0] acc_reg, acc_next;

    // item held between accept and merge
    logic [NUM_CH-1:0][RSW-1:0] pend_sum_reg;
    logic [CW-1:0]      pend_addr_reg;
    logic               pend_first_reg;
    logic               pend_row_end_reg;
    logic [CNTW-1:0]    pend_count_reg;
    logic [RW-1:0]      pend_orow_reg;
    logic               pend_last_reg;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_last_reg;

    bda_state_t state_reg, state_next;

    logic in_accept;
    logic row_last, frame_last_row, col_end, row_end;
    logic [NUM_CH-1:0][RSW-1:0]  sum_in;
    logic [NUM_CH-1:0][SUMW-1:0] total;
    logic [NUM_CH*SUMW-1:0]      rd_data;
    logic [NUM_CH-1:0][SUMW-1:0] prior;
    logic mem_wr, div_start, out_load;
    logic [CW+RW-1:0] ocol_ext;
    div_stat_t div_stat;

    // effective register values
    always_comb begin
        if (scale_reg == '0) begin
            f_eff = FW'(1);
        end else if ({1'b0, scale_reg} > (SCALE_W + 1)'(MAX_FACTOR)) begin
            f_eff = FW'(MAX_FACTOR);
        end else begin
            f_eff = FW'(scale_reg);
        end
        if (width_reg == '0) begin
            w_eff = CMPW'(1);
        end else if ({1'b0, width_reg} > (DIM_W + 1)'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(HEIGHT_CAP)) begin
            h_eff = DIM_W'(HEIGHT_CAP);
        end else begin
            h_eff = height_reg;
        end
    end

    assign restart = cfg_wr_en && (cfg_index == REG_SCALE_FACTOR ||
                                   cfg_index == REG_SOURCE_WIDTH ||
                                   cfg_index == REG_SOURCE_HEIGHT);

    always_comb begin
        scale_next  = scale_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCALE_FACTOR:  scale_next  = cfg_data[SCALE_W-1:0];
                REG_SOURCE_WIDTH:  width_next  = cfg_data[DIM_W-1:0];
                REG_SOURCE_HEIGHT: height_next = cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // block position flags for the item at the input
    assign row_last       = ({1'b0, col_reg} + CMPW'(1)) >= w_eff;
    assign frame_last_row = ({1'b0, row_reg} + DIM_W'(1)) >= h_eff;
    assign col_end        = ({1'b0, cib_reg} + (FW + 1)'(1)) >= {1'b0, f_eff} || row_last;
    assign row_end        = ({1'b0, rib_reg} + (FW + 1)'(1)) >= {1'b0, f_eff}
                            || frame_last_row;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum_in[c] = acc_reg[c] + RSW'(s_tdata[c*CH_W +: CH_W]);
        end
    end

    assign in_accept = s_tvalid && s_tready;

    // position update
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        cib_next  = cib_reg;
        rib_next  = rib_reg;
        bcol_next = bcol_reg;
        brow_next = brow_reg;
        acc_next  = acc_reg;
        if (restart) begin
            col_next  = '0;
            row_next  = '0;
            cib_next  = '0;
            rib_next  = '0;
            bcol_next = '0;
            brow_next = '0;
            acc_next  = '0;
        end else if (in_accept) begin
            acc_next = col_end ? '0 : sum_in;
            if (row_last) begin
                col_next  = '0;
                cib_next  = '0;
                bcol_next = '0;
                if (frame_last_row) begin
                    row_next  = '0;
                    rib_next  = '0;
                    brow_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                    rib_next = row_end ? '0 : rib_reg + 1'b1;
                    if (row_end) begin
                        brow_next = brow_reg + 1'b1;
                    end
                end
            end else begin
                col_next = col_reg + 1'b1;
                cib_next = col_end ? '0 : cib_reg + 1'b1;
                if (col_end) begin
                    bcol_next = bcol_reg + 1'b1;
                end
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_accept && col_end) state_next = ST_MERGE;
            ST_MERGE: state_next = pend_row_end_reg ? ST_DIV : ST_IDLE;
            ST_DIV:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        mem_wr    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_MERGE: begin
                mem_wr    = !pend_row_end_reg;
                div_start = pend_row_end_reg;
            end
            ST_DIV:   out_load = div_stat.done && (!m_valid_reg || m_tready);
            default:  ;
        endcase
    end

    // merge: first row of a block starts from zero
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prior[c] = pend_first_reg ? '0 : rd_data[c*SUMW +: SUMW];
            total[c] = prior[c] + SUMW'(pend_sum_reg[c]);
        end
    end

    bda_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (NUM_CH * SUMW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (pend_addr_reg),
        .wr_data (total),
        .rd_en   (in_accept),
        .rd_addr (bcol_reg),
        .rd_data (rd_data)
    );

    bda_divider #(
        .SUMW (SUMW),
        .CNTW (CNTW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .take     (out_load),
        .dividend (total),
        .divisor  (pend_count_reg),
        .stat     (div_stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= SCALE_RESET;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
            acc_reg     <= '0;
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            scale_reg   <= scale_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            cib_reg     <= cib_next;
            rib_reg     <= rib_next;
            bcol_reg    <= bcol_next;
            brow_reg    <= brow_next;
            acc_reg     <= acc_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pend_sum_reg     <= sum_in;
            pend_addr_reg    <= bcol_reg;
            pend_first_reg   <= (rib_reg == '0);
            pend_row_end_reg <= row_end;
            pend_count_reg   <= CNTW'(cib_reg + 1'b1) * CNTW'(rib_reg + 1'b1);
            pend_orow_reg    <= brow_reg;
            pend_last_reg    <= row_last && frame_last_row;
        end
    end

    // output column keeps only its low 12 bits
    assign ocol_ext = {{RW{1'b0}}, pend_addr_reg};

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {pend_orow_reg, ocol_ext[RW-1:0],
                           div_stat.quot[2], div_stat.quot[1], div_stat.quot[0]};
            m_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
